[src/ttn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle tangent/normal package
// Shared widths, types and helpers for the per-triangle tangent unit.
// ----------------------------------------------------------------------------
package ttn_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int QW = COORD_BITS - 1;
    localparam int NW = AW + FRAC_BITS;
    localparam int CW = AW + QW;
    localparam int RW = AW + 1;
    localparam int CNTW = $clog2(QW);

    localparam int NUM_FIELDS = 5;
    localparam int NUM_STEPS  = 14;
    localparam int SW         = $clog2(NUM_STEPS);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic t_diff f_diff(input t_coord a, input t_coord b);
        f_diff = t_diff'(a) - t_diff'(b);
    endfunction

endpackage
`default_nettype wire

[src/triangle_tangent_normal.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle tangent and face normal
// Operation: the first two vertices of a triangle are only registered; the third
// starts the work: 14 products on one shared 33x33 multiplier, each through
// operand load, multiply and accumulate, a finish step per product pair, then,
// for each tangent component of a non-degenerate triangle, an overflow check
// that saturates it or starts a one-bit-per-cycle divider for its 31 quotient
// bits, and last the output load. Throughput: one triangle per three vertex
// transfers; the input stalls during that work and while a finished result
// waits. Reset: synchronous active-low; clears the vertex phase, sequencer and output valid.
// ----------------------------------------------------------------------------
module triangle_tangent_normal (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire ttn_pkg::t_coord i_pos_x,
    input  wire ttn_pkg::t_coord i_pos_y,
    input  wire ttn_pkg::t_coord i_pos_z,
    input  wire ttn_pkg::t_coord i_tex_u,
    input  wire ttn_pkg::t_coord i_tex_v,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output ttn_pkg::t_coord      o_tangent_x,
    output ttn_pkg::t_coord      o_tangent_y,
    output ttn_pkg::t_coord      o_tangent_z,
    output ttn_pkg::t_coord      o_normal_x,
    output ttn_pkg::t_coord      o_normal_y,
    output ttn_pkg::t_coord      o_normal_z,
    output logic                 o_degenerate
);
    import ttn_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPS  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DCHK = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [1:0] PH_V0 = 2'd0;
    localparam logic [1:0] PH_V1 = 2'd1;
    localparam logic [1:0] PH_V2 = 2'd2;

    localparam int F_X = 0;
    localparam int F_Y = 1;
    localparam int F_Z = 2;
    localparam int F_U = 3;
    localparam int F_V = 4;

    localparam logic [SW-1:0] ST_DET  = SW'(1);
    localparam logic [SW-1:0] ST_TAN  = SW'(9);
    localparam logic [SW-1:0] ST_LAST = SW'(NUM_STEPS - 1);

    logic [2:0]           r_state;
    logic [1:0]           r_phase;
    logic [SW-1:0]        r_step;
    t_coord               r_v0 [NUM_FIELDS];
    t_coord               r_v1 [NUM_FIELDS];
    t_coord               r_v2 [NUM_FIELDS];
    t_diff                r_opa;
    t_diff                r_opb;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic [AW-1:0]        r_den;
    logic                 r_dneg;
    logic                 r_degen;
    logic [AW-1:0]        r_num;
    logic                 r_tneg;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_nlo;
    logic [QW-1:0]        r_q;
    logic [CNTW-1:0]      r_cnt;
    t_coord               r_tan [3];
    t_coord               r_nrm [3];
    logic                 r_ovalid;
    t_coord               r_otan [3];
    t_coord               r_onrm [3];
    logic                 r_odeg;

    t_coord  w_in [NUM_FIELDS];
    t_diff   w_opa;
    t_diff   w_opb;
    t_diff   w_du1u, w_du1v, w_du2u, w_du2v;
    t_diff   w_dp1 [3];
    t_diff   w_dp2 [3];
    t_diff   w_a [3];
    t_diff   w_b [3];
    logic              w_acc_neg;
    logic [AW-1:0]     w_abs;
    logic [AW-1:0]     w_nmag;
    logic              w_nsat;
    t_coord            w_nval;
    logic [1:0]        w_nidx;
    logic [1:0]        w_tidx;
    logic              w_ovf;
    logic [RW-1:0]     w_t;
    logic              w_ge;
    logic [QW-1:0]     w_q;
    t_coord            w_qval;
    logic              w_accept;
    logic              w_oload;

    assign w_in[F_X] = i_pos_x;
    assign w_in[F_Y] = i_pos_y;
    assign w_in[F_Z] = i_pos_z;
    assign w_in[F_U] = i_tex_u;
    assign w_in[F_V] = i_tex_v;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_oload  = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    assign w_du1u = f_diff(r_v1[F_U], r_v0[F_U]);
    assign w_du1v = f_diff(r_v1[F_V], r_v0[F_V]);
    assign w_du2u = f_diff(r_v2[F_U], r_v0[F_U]);
    assign w_du2v = f_diff(r_v2[F_V], r_v0[F_V]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dp1[i] = f_diff(r_v1[i], r_v0[i]);
            w_dp2[i] = f_diff(r_v2[i], r_v0[i]);
            w_a[i]   = f_diff(r_v0[i], r_v1[i]);
            w_b[i]   = f_diff(r_v2[i], r_v1[i]);
        end
    end

    always_comb begin
        unique case (r_step)
            SW'(0):  begin w_opa = w_du1u;     w_opb = w_du2v; end
            SW'(1):  begin w_opa = w_du1v;     w_opb = w_du2u; end
            SW'(2):  begin w_opa = w_a[F_Y];   w_opb = w_b[F_Z]; end
            SW'(3):  begin w_opa = w_a[F_Z];   w_opb = w_b[F_Y]; end
            SW'(4):  begin w_opa = w_a[F_Z];   w_opb = w_b[F_X]; end
            SW'(5):  begin w_opa = w_a[F_X];   w_opb = w_b[F_Z]; end
            SW'(6):  begin w_opa = w_a[F_X];   w_opb = w_b[F_Y]; end
            SW'(7):  begin w_opa = w_a[F_Y];   w_opb = w_b[F_X]; end
            SW'(8):  begin w_opa = w_dp1[F_X]; w_opb = w_du2v; end
            SW'(9):  begin w_opa = w_dp2[F_X]; w_opb = w_du1v; end
            SW'(10): begin w_opa = w_dp1[F_Y]; w_opb = w_du2v; end
            SW'(11): begin w_opa = w_dp2[F_Y]; w_opb = w_du1v; end
            SW'(12): begin w_opa = w_dp1[F_Z]; w_opb = w_du2v; end
            SW'(13): begin w_opa = w_dp2[F_Z]; w_opb = w_du1v; end
            default: begin w_opa = '0;         w_opb = '0; end
        endcase
    end

    assign w_acc_neg = r_acc[AW-1];
    assign w_abs     = w_acc_neg ? AW'(-r_acc) : AW'(r_acc);
    assign w_nmag    = w_abs >> FRAC_BITS;
    assign w_nsat    = |w_nmag[AW-1:QW];
    assign w_nidx    = r_step[2:1] - 2'd1;
    assign w_tidx    = r_step[2:1];

    always_comb begin
        if (w_nsat) begin
            w_nval = w_acc_neg ? COORD_MIN : COORD_MAX;
        end else if (w_acc_neg) begin
            w_nval = -t_coord'({1'b0, w_nmag[QW-1:0]});
        end else begin
            w_nval = t_coord'({1'b0, w_nmag[QW-1:0]});
        end
    end

    assign w_ovf  = {{(CW-NW){1'b0}}, r_num, {FRAC_BITS{1'b0}}} >= {r_den, {QW{1'b0}}};
    assign w_t    = {r_rem[RW-2:0], r_nlo[QW-1]};
    assign w_ge   = w_t >= RW'(r_den);
    assign w_q    = {r_q[QW-2:0], w_ge};
    assign w_qval = r_tneg ? -t_coord'({1'b0, w_q}) : t_coord'({1'b0, w_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_V0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (r_phase)
                            PH_V0: begin
                                r_v0    <= w_in;
                                r_phase <= PH_V1;
                            end
                            PH_V1: begin
                                r_v1    <= w_in;
                                r_phase <= PH_V2;
                            end
                            default: begin
                                r_v2    <= w_in;
                                r_phase <= PH_V0;
                                r_step  <= '0;
                                r_state <= S_OPS;
                            end
                        endcase
                    end
                end
                S_OPS: begin
                    r_opa   <= w_opa;
                    r_opb   <= w_opb;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_opa * r_opb;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_step[0]) begin
                        r_acc   <= AW'(r_prod);
                        r_step  <= r_step + SW'(1);
                        r_state <= S_OPS;
                    end else begin
                        r_acc   <= r_acc - AW'(r_prod);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_step == ST_DET) begin
                        r_den   <= w_abs;
                        r_dneg  <= w_acc_neg;
                        r_degen <= (r_acc == '0);
                        r_step  <= r_step + SW'(1);
                        r_state <= S_OPS;
                    end else if (r_step < ST_TAN) begin
                        r_nrm[w_nidx] <= w_nval;
                        r_step        <= r_step + SW'(1);
                        r_state       <= S_OPS;
                    end else if (r_degen) begin
                        r_tan[w_tidx] <= '0;
                        r_step        <= r_step + SW'(1);
                        r_state       <= (r_step == ST_LAST) ? S_DONE : S_OPS;
                    end else begin
                        r_num   <= w_abs;
                        r_tneg  <= w_acc_neg ^ r_dneg;
                        r_state <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    if (w_ovf) begin
                        r_tan[w_tidx] <= r_tneg ? COORD_MIN : COORD_MAX;
                        r_step        <= r_step + SW'(1);
                        r_state       <= (r_step == ST_LAST) ? S_DONE : S_OPS;
                    end else begin
                        r_rem   <= RW'(r_num >> (QW - FRAC_BITS));
                        r_nlo   <= {r_num[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                        r_q     <= '0;
                        r_cnt   <= CNTW'(QW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? (w_t - RW'(r_den)) : w_t;
                    r_nlo <= {r_nlo[QW-2:0], 1'b0};
                    r_q   <= w_q;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == '0) begin
                        r_tan[w_tidx] <= w_qval;
                        r_step        <= r_step + SW'(1);
                        r_state       <= (r_step == ST_LAST) ? S_DONE : S_OPS;
                    end
                end
                S_DONE: begin
                    if (w_oload) begin
                        r_otan  <= r_tan;
                        r_onrm  <= r_nrm;
                        r_odeg  <= r_degen;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_tangent_x  = r_otan[F_X];
    assign o_tangent_y  = r_otan[F_Y];
    assign o_tangent_z  = r_otan[F_Z];
    assign o_normal_x   = r_onrm[F_X];
    assign o_normal_y   = r_onrm[F_Y];
    assign o_normal_z   = r_onrm[F_Z];
    assign o_degenerate = r_odeg;

endmodule
`default_nettype wire

[src/ttn_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle tangent/normal port checker
// Watches the top-level ports for output handshake and result consistency.
// ----------------------------------------------------------------------------
module ttn_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire ttn_pkg::t_coord o_tangent_x,
    input wire ttn_pkg::t_coord o_tangent_y,
    input wire ttn_pkg::t_coord o_tangent_z,
    input wire ttn_pkg::t_coord o_normal_x,
    input wire logic            o_degenerate
);
    import ttn_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_tangent_x) && $stable(o_normal_x)
            && $stable(o_degenerate))
        else $error("stalled output payload changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_tangent_x == '0 && o_tangent_y == '0
            && o_tangent_z == '0)
        else $error("degenerate result with nonzero tangent");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a triangle in progress");

endmodule

bind triangle_tangent_normal ttn_checker u_ttn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_tangent_x  (o_tangent_x),
    .o_tangent_y  (o_tangent_y),
    .o_tangent_z  (o_tangent_z),
    .o_normal_x   (o_normal_x),
    .o_degenerate (o_degenerate)
);
`default_nettype wire

[dv/triangle_tangent_normal_test.sv]
// ----------------------------------------------------------------------------
// Triangle tangent/normal testbench
// Streams triangle-list vertices through the block under random source gaps
// and sink stalls. Each third vertex closes a triangle whose result is predicted in wide signed arithmetic,
// and every result transfer is compared field by field with the oldest
// expected triangle.
// ----------------------------------------------------------------------------
module triangle_tangent_normal_test;
    import ttn_pkg::*;

    typedef struct {
        t_coord f [NUM_FIELDS];
    } t_vertex;

    typedef struct {
        t_coord tx, ty, tz, nx, ny, nz;
        logic   dg;
    } t_tri_result;

    typedef logic signed [127:0] t_wide;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b0;
    t_coord i_pos_x = '0, i_pos_y = '0, i_pos_z = '0, i_tex_u = '0, i_tex_v = '0;
    logic   o_stall, o_valid, o_degenerate;
    t_coord o_tangent_x, o_tangent_y, o_tangent_z, o_normal_x, o_normal_y, o_normal_z;

    triangle_tangent_normal u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tex_u(i_tex_u), .i_tex_v(i_tex_v),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y),
        .o_tangent_z(o_tangent_z), .o_normal_x(o_normal_x),
        .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    t_tri_result expected_tris [$];
    t_vertex     corner0, corner1;
    int          corner_phase = 0;
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_cycles = 0;
    bit          in_reset = 1'b1;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_coord saturate(t_wide v);
        if (v > t_wide'(COORD_MAX)) return COORD_MAX;
        if (v < t_wide'(COORD_MIN)) return COORD_MIN;
        return t_coord'(v);
    endfunction

    function automatic t_coord cross_comp(t_wide a, t_wide b, t_wide c, t_wide d);
        t_wide s;
        s = a * b - c * d;
        return saturate(s / 128'sd65536);
    endfunction

    function automatic t_tri_result predict_triangle(t_vertex v0, t_vertex v1, t_vertex v2);
        t_wide p0 [5], p1 [5], p2 [5], ea [3], eb [3];
        t_wide du1u, du1v, du2u, du2v, det, num;
        t_tri_result r;
        t_coord tan [3];
        for (int i = 0; i < 5; i++) begin
            p0[i] = v0.f[i];
            p1[i] = v1.f[i];
            p2[i] = v2.f[i];
        end
        du1u = p1[3] - p0[3];
        du1v = p1[4] - p0[4];
        du2u = p2[3] - p0[3];
        du2v = p2[4] - p0[4];
        det = du1u * du2v - du1v * du2u;
        for (int i = 0; i < 3; i++) begin
            ea[i] = p0[i] - p1[i];
            eb[i] = p2[i] - p1[i];
            if (det == 0) begin
                tan[i] = '0;
            end else begin
                num = (p1[i] - p0[i]) * du2v - (p2[i] - p0[i]) * du1v;
                tan[i] = saturate((num * 128'sd65536) / det);
            end
        end
        r.tx = tan[0];
        r.ty = tan[1];
        r.tz = tan[2];
        r.nx = cross_comp(ea[1], eb[2], ea[2], eb[1]);
        r.ny = cross_comp(ea[2], eb[0], ea[0], eb[2]);
        r.nz = cross_comp(ea[0], eb[1], ea[1], eb[0]);
        r.dg = (det == 0);
        return r;
    endfunction

    task automatic send_vertex(t_vertex v);
        while (!quiet && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= v.f[0];
        i_pos_y <= v.f[1];
        i_pos_z <= v.f[2];
        i_tex_u <= v.f[3];
        i_tex_v <= v.f[4];
        do @(posedge i_clk); while (o_stall);
        case (corner_phase)
            0: corner0 = v;
            1: corner1 = v;
            default: expected_tris = {expected_tris, predict_triangle(corner0, corner1, v)};
        endcase
        corner_phase = (corner_phase + 1) % 3;
    endtask

    task automatic send_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_vertex make_vertex(t_coord x, t_coord y, t_coord z, t_coord u,
                                            t_coord w);
        t_vertex v;
        v.f[0] = x; v.f[1] = y; v.f[2] = z; v.f[3] = u; v.f[4] = w;
        return v;
    endfunction

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(2 * 65536 * 64) - 65536 * 64);
            2: return $urandom_range(1) ? COORD_MAX - t_coord'($urandom_range(3))
                                        : COORD_MIN + t_coord'($urandom_range(3));
            default: return t_coord'($urandom_range(2 * 65536) - 65536);
        endcase
    endfunction

    task automatic send_random_triangle();
        t_vertex v [3];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 5; i++)
                v[k].f[i] = rand_coord(mode < 3 ? 0 : mode < 7 ? 1 : mode == 7 ? 2 : 3);
        if ($urandom_range(9) == 0) begin
            v[2].f[3] = v[0].f[3];
            v[2].f[4] = v[0].f[4];
        end else if ($urandom_range(19) == 0) begin
            v[1].f[3] = v[0].f[3] + 65536;
            v[1].f[4] = v[0].f[4];
            v[2].f[3] = v[0].f[3] - 131072;
            v[2].f[4] = v[0].f[4];
        end
        for (int k = 0; k < 3; k++) send_vertex(v[k]);
    endtask

    task automatic wait_drained();
        while (expected_tris.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        t_coord one;
        one = 32'sd65536;
        // unit right triangle with aligned uv
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(one, 0, 0, one, 0));
        send_vertex(make_vertex(0, one, 0, 0, one));
        // all-zero triangle, degenerate
        repeat (3) send_vertex(make_vertex(0, 0, 0, 0, 0));
        // extremes everywhere: saturating normal, tangent in range
        send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        send_vertex(make_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN + 1));
        // collinear uv, degenerate with a real normal
        send_vertex(make_vertex(COORD_MAX, 0, COORD_MIN, 5, 7));
        send_vertex(make_vertex(COORD_MIN, COORD_MAX, 0, 10, 14));
        send_vertex(make_vertex(0, COORD_MIN, COORD_MAX, 15, 21));
        // tiny determinant, huge numerator
        send_vertex(make_vertex(COORD_MIN, 0, COORD_MAX, 0, 0));
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1, 0));
        send_vertex(make_vertex(COORD_MIN, COORD_MIN, 0, 0, 1));
        // negative tangent truncated toward zero
        send_vertex(make_vertex(-1, 3, -7, 0, 0));
        send_vertex(make_vertex(2, -5, 1, 3, 0));
        send_vertex(make_vertex(-4, 6, 9, 0, -3));
        send_vertex(make_vertex(-1, -1, -1, -1, -1));
        send_vertex(make_vertex(1, -1, 1, -1, 1));
        send_vertex(make_vertex(-1, 1, -1, 1, -1));
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 150; n++) begin
            quiet = (n >= 60 && n < 90);
            send_random_triangle();
            if ($urandom_range(49) == 0) send_vertex(make_vertex(rand_coord(0),
                rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0)));
        end
        quiet = 1'b0;
    endtask

    task automatic test_sink_hold_off();
        hold_requests++;
        for (int n = 0; n < 20; n++) send_random_triangle();
    endtask

    task automatic test_pause_until_drained();
        send_idle();
        wait_drained();
        for (int n = 0; n < 60; n++) send_random_triangle();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (holds_served != hold_requests) begin
            i_stall      <= 1'b1;
            hold_cycles  <= 1999;
            holds_served <= holds_served + 1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 19);
        end
    end

    task automatic compare_field(string name, t_coord got, t_coord want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_tri_result e;
        if (!in_reset && o_valid && !i_stall) begin
            if (expected_tris.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: result with none expected");
            end else begin
                e = expected_tris.pop_front();
                compare_field("tangent_x", o_tangent_x, e.tx);
                compare_field("tangent_y", o_tangent_y, e.ty);
                compare_field("tangent_z", o_tangent_z, e.tz);
                compare_field("normal_x", o_normal_x, e.nx);
                compare_field("normal_y", o_normal_y, e.ny);
                compare_field("normal_z", o_normal_z, e.nz);
                compare_field("degenerate", t_coord'(o_degenerate), t_coord'(e.dg));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_reset = 1'b0;
        test_directed_cases();
        test_random_stream();
        test_sink_hold_off();
        test_pause_until_drained();
        send_idle();
        wait_drained();
        if (mismatches == 0 && expected_tris.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
